[design/indexed_stencil_update_assert.svh]
// assertion macros for the indexed stencil update block
// expects clk and rst_n in the scope of each use
`ifndef INDEXED_STENCIL_UPDATE_ASSERT_SVH
`define INDEXED_STENCIL_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ISU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ISU_ASSERT(lbl, prop, msg)
`define ISU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/isu_pkg.sv]
// shared constants, types and helpers for the indexed stencil update block
// no dependencies
`default_nettype none
package isu_pkg;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 15;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 6;
  localparam int CFG_AW  = 4;
  localparam int PDATA_W = 32;
  localparam int SET_WORDS = 16;
  localparam int SET_SHIFT = 4;
  localparam int FRAC_SHIFT = 29;
  localparam int N_TERMS = 14;
  localparam int N_LANES = 3;

  localparam int DEF_MAX_POINTS = 32768;
  localparam int DEF_MAX_SETS   = 64;
  localparam int DEF_MAX_DIM    = 32;

  localparam logic [KIND_W-1:0] K_COEF_WR = 3'd0;
  localparam logic [KIND_W-1:0] K_SET_WR  = 3'd1;
  localparam logic [KIND_W-1:0] K_OLD_WR  = 3'd2;
  localparam logic [KIND_W-1:0] K_PREV_WR = 3'd3;
  localparam logic [KIND_W-1:0] K_UPDATE  = 3'd4;
  localparam logic [KIND_W-1:0] K_ROTATE  = 3'd5;
  localparam logic [KIND_W-1:0] K_READ    = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;

  localparam logic [3:0] C_OLD_CTR = 4'd7;
  localparam logic [3:0] C_GAIN    = 4'd8;
  localparam logic [3:0] C_OLD_BASE = 4'd8;

  typedef struct packed {
    logic       rd;
    logic [2:0] we_fld;
    logic       we_set;
  } fm_req_t;

  typedef struct packed {
    logic clr;
    logic term;
    logic sub;
    logic sat1;
    logic dsel;
  } mac_ctl_t;

  // coefficient word for neighbor j, previous-field term or older-field term
  function automatic logic [3:0] coef_idx(input logic [2:0] j, input logic older);
    logic [3:0] r;
    if (!older) r = {1'b0, j};
    else if (j == 3'd0) r = C_OLD_CTR;
    else r = 4'(C_OLD_BASE + {1'b0, j});
    return r;
  endfunction
endpackage
`default_nettype wire

[design/isu_if.sv]
// request channel interfaces for the indexed stencil update block
// depends on isu_pkg
`default_nettype none
interface isu_in_if;
  import isu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ADDR_W-1:0]        address;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, kind, address, value, input ready);
  modport sink   (input valid, kind, address, value, output ready);
endinterface

interface isu_out_if;
  import isu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STAT_W-1:0]        status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

[design/isu_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on isu_pkg
`default_nettype none
module isu_div #(
  parameter int N = 15,
  parameter int D = 6
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quot,
  output logic [D-1:0]      rem
);
  import isu_pkg::*;
  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [N-1:0]  quo_r;
  logic [D-1:0]  rem_r, dvs_r;
  logic [D:0]    trial, diff;
  logic          ge;

  assign trial = {rem_r, quo_r[N-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[N-2:0], ge};
      rem_r <= ge ? diff[D-1:0] : trial[D-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

[design/isu_fmem.sv]
// field memory: three field lanes and a set-index lane on one shared port
// clears every entry after reset; depends on isu_pkg
`default_nettype none
module isu_fmem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int SW    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire isu_pkg::fm_req_t      req,
  input  wire logic [AW-1:0]         addr,
  input  wire logic [isu_pkg::DATA_W-1:0] wfld,
  input  wire logic [SW-1:0]         wset,
  output logic [isu_pkg::N_LANES-1:0][isu_pkg::DATA_W-1:0] rd_fld,
  output logic [SW-1:0]              rd_set,
  output logic                       busy
);
  import isu_pkg::*;

  logic [DATA_W-1:0] fld_mem [N_LANES][DEPTH];
  logic [SW-1:0]     set_mem [DEPTH];
  logic [AW-1:0]     clr_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == AW'(DEPTH - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      for (int l = 0; l < N_LANES; l++) fld_mem[l][clr_r] <= '0;
      set_mem[clr_r] <= '0;
    end else begin
      for (int l = 0; l < N_LANES; l++) begin
        if (req.we_fld[l]) fld_mem[l][addr] <= wfld;
      end
      if (req.we_set) set_mem[addr] <= wset;
      if (req.rd) begin
        for (int l = 0; l < N_LANES; l++) rd_fld[l] <= fld_mem[l][addr];
        rd_set <= set_mem[addr];
      end
    end
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

[design/isu_mac.sv]
// multiply-accumulate path: truncated products, 64-bit sum, two saturations
// depends on isu_pkg
`default_nettype none
module isu_mac (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire isu_pkg::mac_ctl_t               ctl,
  input  wire logic signed [isu_pkg::DATA_W-1:0] opnd,
  input  wire logic signed [isu_pkg::DATA_W-1:0] coef,
  output logic signed [isu_pkg::DATA_W-1:0]      res,
  output logic                                 clip
);
  import isu_pkg::*;
  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;

  logic signed [DATA_W-1:0] mul_a, d_r;
  logic signed [63:0]       prod_nxt, prod_r, acc_r, shp;
  logic                     tv_r, sub_r, clip_r, clip_d, clip_f;
  logic signed [DATA_W-1:0] d_nxt;

  assign mul_a    = ctl.dsel ? d_r : opnd;
  assign prod_nxt = mul_a * coef;
  assign shp      = prod_r >>> FRAC_SHIFT;

  always_comb begin
    clip_d = 1'b1;
    if (acc_r > SMAX) d_nxt = DATA_W'(SMAX);
    else if (acc_r < SMIN) d_nxt = DATA_W'(SMIN);
    else begin
      d_nxt  = DATA_W'(acc_r);
      clip_d = 1'b0;
    end
    clip_f = 1'b1;
    if (shp > SMAX) res = DATA_W'(SMAX);
    else if (shp < SMIN) res = DATA_W'(SMIN);
    else begin
      res    = DATA_W'(shp);
      clip_f = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r   <= 1'b0;
      clip_r <= 1'b0;
    end else begin
      tv_r <= ctl.term;
      if (ctl.clr) clip_r <= 1'b0;
      else if (ctl.sat1) clip_r <= clip_d;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.term || ctl.dsel) prod_r <= prod_nxt;
    if (ctl.term) sub_r <= ctl.sub;
    if (ctl.clr) acc_r <= '0;
    else if (tv_r) acc_r <= sub_r ? acc_r - shp : acc_r + shp;
    if (ctl.sat1) d_r <= d_nxt;
  end

  assign clip = clip_r | clip_f;
endmodule
`default_nettype wire

[design/indexed_stencil_update.sv]
// indexed stencil update top level: request channels, config port, sequencer
// depends on isu_pkg, isu_if, isu_div, isu_fmem, isu_mac and the assertion header
//
// use: requests enter on in_ch (kind, address, value); every request gives
// exactly one response on out_ch (result_value, status) in request order.
// grid_x, grid_y, grid_z are set over the apb port (byte addresses 0, 4, 8);
// the user must write them only while the block is idle, which the block
// does not enforce. in_ch.ready stays low after a write until settle_r is zero.
// writes, rotate and out-of-range requests finish in the dispatch state; a
// read first waits for the field memory read. an update runs two bit-serial
// divisions to find the point coordinates, then fourteen neighbor terms and
// the gain coefficient stream through the single coefficient read port and
// the one multiplier. one request is worked on at a time.
// reset: grid sizes go to 32, roles to zero, and the field memory is swept
// to zero, one entry a cycle over all MAX_POINTS entries, with in_ch.ready low.
// stall: a finished response waits in the output register while the next
// request is taken in; the block then holds until out_ch.ready frees the
// register.
`default_nettype none
`include "indexed_stencil_update_assert.svh"
module indexed_stencil_update #(
  parameter int MAX_POINTS = isu_pkg::DEF_MAX_POINTS,
  parameter int MAX_SETS   = isu_pkg::DEF_MAX_SETS,
  parameter int MAX_DIM    = isu_pkg::DEF_MAX_DIM
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  isu_in_if.sink                           in_ch,
  isu_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [isu_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [isu_pkg::PDATA_W-1:0] pwdata,
  output logic [isu_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import isu_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int SW  = $clog2(MAX_SETS);
  localparam int CW  = SW + SET_SHIFT;
  localparam int CDEPTH = MAX_SETS * SET_WORDS;
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int NBW = ((AW > 2 * DW) ? AW : 2 * DW) + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_DIV2  = 4'd4;
  localparam logic [3:0] S_CTR   = 4'd5;
  localparam logic [3:0] S_SETW  = 4'd6;
  localparam logic [3:0] S_TERMS = 4'd7;
  localparam logic [3:0] S_CREAD = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_SAT   = 4'd10;
  localparam logic [3:0] S_MUL   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  // neighbor order within an update
  localparam logic [2:0] NB_CTR = 3'd0;
  localparam logic [2:0] NB_XP  = 3'd1;
  localparam logic [2:0] NB_XM  = 3'd2;
  localparam logic [2:0] NB_YP  = 3'd3;
  localparam logic [2:0] NB_YM  = 3'd4;
  localparam logic [2:0] NB_ZP  = 3'd5;
  localparam logic [2:0] NB_ZM  = 3'd6;
  localparam logic [3:0] LAST_STEP = 4'(N_TERMS - 1);

  // config registers and derived grid geometry
  logic [CFG_W-1:0] gx_r, gy_r, gz_r;
  logic [DW-1:0]    nx_r, ny_r, nz_r, ex, ey, ez;
  logic [2*DW-1:0]  nxy_r;
  logic [3*DW-1:0]  nraw;
  logic [PW-1:0]    npts_r;
  logic [1:0]       settle_r;
  logic             cfg_we;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
    else r = DW'(v);
    return r;
  endfunction

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_GRID_X: prdata = PDATA_W'(gx_r);
      REG_GRID_Y: prdata = PDATA_W'(gy_r);
      REG_GRID_Z: prdata = PDATA_W'(gz_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r     <= CFG_W'(32);
      gy_r     <= CFG_W'(32);
      gz_r     <= CFG_W'(32);
      settle_r <= 2'd0;
    end else begin
      if (cfg_we) begin
        settle_r <= 2'd3;
        unique case (paddr[3:2])
          REG_GRID_X: gx_r <= pwdata[CFG_W-1:0];
          REG_GRID_Y: gy_r <= pwdata[CFG_W-1:0];
          REG_GRID_Z: gz_r <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 1'b1;
      end
    end
  end

  assign ex   = eff_dim(gx_r);
  assign ey   = eff_dim(gy_r);
  assign ez   = eff_dim(gz_r);
  assign nraw = nxy_r * nz_r;

  // geometry pipeline: dims and x-y plane size, then point count with cap
  always_ff @(posedge clk) begin
    nx_r   <= ex;
    ny_r   <= ey;
    nz_r   <= ez;
    nxy_r  <= ex * ey;
    npts_r <= (64'(nraw) > 64'(MAX_POINTS)) ? PW'(MAX_POINTS) : PW'(nraw);
  end

  // request registers
  logic [3:0]        state_r;
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] val_r;
  logic [1:0]        role_r;
  logic [1:0]        ln_new, ln_prv, ln_old;
  logic              pt_ok, cf_ok, set_ok, out_free, fm_busy;

  assign ln_new   = role_r;
  assign ln_prv   = (role_r == 2'd2) ? 2'd0 : role_r + 2'd1;
  assign ln_old   = (role_r == 2'd0) ? 2'd2 : role_r - 2'd1;
  assign pt_ok    = 32'(addr_r) < 32'(npts_r);
  assign cf_ok    = 32'(addr_r) < 32'(CDEPTH);
  assign set_ok   = val_r < 32'(MAX_SETS);
  assign out_free = !out_ch.valid || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE) && !fm_busy && (settle_r == 2'd0);

  // coordinate recovery
  logic          div_start, div_done;
  logic [AW-1:0] div_dvd, div_quot;
  logic [DW-1:0] div_dvs, div_rem;
  logic [DW-1:0] x_r, y_r, z_r;

  assign div_dvd   = (state_r == S_DIV1) ? div_quot : AW'(addr_r);
  assign div_dvs   = (state_r == S_DIV1) ? nx_r : ny_r;
  assign div_start = ((state_r == S_DISP) && (kind_r == K_UPDATE) && pt_ok)
                   || ((state_r == S_DIV1) && div_done);

  isu_div #(.N(AW), .D(DW)) u_div (
    .clk, .rst_n,
    .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  // neighbor address for the current step
  logic [3:0]     step_r;
  logic [2:0]     nb;
  logic [NBW-1:0] p_w, nb_addr;
  logic           nb_in, nb_ok;

  assign nb  = step_r[3:1];
  assign p_w = NBW'(addr_r);

  always_comb begin
    case (nb)
      NB_CTR: begin nb_addr = p_w;                nb_in = 1'b1; end
      NB_XP:  begin nb_addr = p_w + NBW'(ny_r);   nb_in = (x_r + 1'b1) < nx_r; end
      NB_XM:  begin nb_addr = p_w - NBW'(ny_r);   nb_in = x_r != '0; end
      NB_YP:  begin nb_addr = p_w + NBW'(1);      nb_in = (y_r + 1'b1) < ny_r; end
      NB_YM:  begin nb_addr = p_w - NBW'(1);      nb_in = y_r != '0; end
      NB_ZP:  begin nb_addr = p_w + NBW'(nxy_r);  nb_in = (z_r + 1'b1) < nz_r; end
      NB_ZM:  begin nb_addr = p_w - NBW'(nxy_r);  nb_in = z_r != '0; end
      default: begin nb_addr = p_w;               nb_in = 1'b0; end
    endcase
    nb_ok = nb_in && (nb_addr < NBW'(npts_r));
  end

  // field memory port
  fm_req_t                        fm_req;
  logic [AW-1:0]                  fm_addr;
  logic [N_LANES-1:0][DATA_W-1:0] fm_rd;
  logic [SW-1:0]                  fm_rset;
  logic signed [DATA_W-1:0]       mac_res;
  logic                           mac_clip;
  logic                           fin_go, disp_done;

  // short requests finish in dispatch once the output register is free
  assign disp_done = (state_r == S_DISP) && out_free
                   && !((kind_r == K_UPDATE || kind_r == K_READ) && pt_ok);
  assign fin_go = (state_r == S_FIN) && out_free;

  always_comb begin
    fm_req  = '0;
    fm_addr = AW'(addr_r);
    if (disp_done) begin
      case (kind_r)
        K_SET_WR:  fm_req.we_set = pt_ok && set_ok;
        K_OLD_WR:  fm_req.we_fld[ln_old] = pt_ok;
        K_PREV_WR: fm_req.we_fld[ln_prv] = pt_ok;
        default: ;
      endcase
    end
    if ((state_r == S_DISP) && (kind_r == K_READ) && pt_ok) fm_req.rd = 1'b1;
    if (state_r == S_CTR) fm_req.rd = 1'b1;
    if (state_r == S_TERMS) begin
      fm_req.rd = 1'b1;
      fm_addr   = AW'(nb_addr);
    end
    if (fin_go) fm_req.we_fld[ln_new] = 1'b1;
  end

  isu_fmem #(.DEPTH(MAX_POINTS), .AW(AW), .SW(SW)) u_fmem (
    .clk, .rst_n,
    .req(fm_req), .addr(fm_addr),
    .wfld(fin_go ? DATA_W'(mac_res) : val_r), .wset(val_r[SW-1:0]),
    .rd_fld(fm_rd), .rd_set(fm_rset), .busy(fm_busy)
  );

  // coefficient memory, one write or one read a cycle
  logic [DATA_W-1:0] coef_mem [CDEPTH];
  logic [DATA_W-1:0] coef_rd_r;
  logic [SW-1:0]     set_r;
  logic              coef_we, coef_re;
  logic [CW-1:0]     coef_ra;

  assign coef_we = disp_done && (kind_r == K_COEF_WR) && cf_ok;
  assign coef_re = (state_r == S_TERMS) || (state_r == S_CREAD);
  assign coef_ra = (state_r == S_CREAD) ? {set_r, C_GAIN}
                                        : {set_r, coef_idx(nb, step_r[0])};

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[CW'(addr_r)] <= val_r;
    if (coef_re) coef_rd_r <= coef_mem[coef_ra];
  end

  // term pipeline tags: the read issued this cycle is used next cycle
  logic     p1_v_r, p1_sub_r, p1_ok_r;
  mac_ctl_t mac_ctl;
  logic signed [DATA_W-1:0] opnd;

  assign opnd = !p1_ok_r ? '0 : (p1_sub_r ? fm_rd[ln_old] : fm_rd[ln_prv]);

  always_comb begin
    mac_ctl      = '0;
    mac_ctl.clr  = state_r == S_CTR;
    mac_ctl.term = p1_v_r;
    mac_ctl.sub  = p1_sub_r;
    mac_ctl.sat1 = state_r == S_SAT;
    mac_ctl.dsel = state_r == S_MUL;
  end

  isu_mac u_mac (
    .clk, .rst_n, .ctl(mac_ctl), .opnd(opnd), .coef(coef_rd_r),
    .res(mac_res), .clip(mac_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else        p1_v_r <= state_r == S_TERMS;
    p1_sub_r <= step_r[0];
    p1_ok_r  <= nb_ok;
  end

  // output register
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_val_r;
  logic [STAT_W-1:0]        out_st_r;
  logic                     load_out;
  logic [DATA_W-1:0]        out_val_nxt;
  logic [STAT_W-1:0]        out_st_nxt;

  always_comb begin
    load_out    = 1'b0;
    out_val_nxt = '0;
    out_st_nxt  = ST_OK;
    if (disp_done) begin
      load_out = 1'b1;
      case (kind_r)
        K_COEF_WR: out_st_nxt = cf_ok ? ST_OK : ST_RANGE;
        K_SET_WR:  out_st_nxt = (pt_ok && set_ok) ? ST_OK : ST_RANGE;
        K_OLD_WR, K_PREV_WR, K_UPDATE, K_READ:
                   out_st_nxt = pt_ok ? ST_OK : ST_RANGE;
        default:   out_st_nxt = ST_OK;
      endcase
    end else if ((state_r == S_RDW) && out_free) begin
      load_out    = 1'b1;
      out_val_nxt = fm_rd[ln_new];
    end else if (fin_go) begin
      load_out    = 1'b1;
      out_val_nxt = mac_res;
      out_st_nxt  = mac_clip ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load_out) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (load_out) begin
      out_val_r <= out_val_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.status       = out_st_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      role_r  <= 2'd0;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) state_r <= S_DISP;
        S_DISP: begin
          if (disp_done) begin
            if (kind_r == K_ROTATE) role_r <= ln_old;
            state_r <= S_IDLE;
          end else if (pt_ok && kind_r == K_READ) begin
            state_r <= S_RDW;
          end else if (pt_ok && kind_r == K_UPDATE) begin
            state_r <= S_DIV1;
          end
        end
        S_RDW:  if (out_free) state_r <= S_IDLE;
        S_DIV1: if (div_done) state_r <= S_DIV2;
        S_DIV2: if (div_done) state_r <= S_CTR;
        S_CTR:  state_r <= S_SETW;
        S_SETW: begin
          step_r  <= '0;
          state_r <= S_TERMS;
        end
        S_TERMS: begin
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) state_r <= S_CREAD;
        end
        S_CREAD: state_r <= S_WAIT;
        S_WAIT:  state_r <= S_SAT;
        S_SAT:   state_r <= S_MUL;
        S_MUL:   state_r <= S_FIN;
        S_FIN:   if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      addr_r <= in_ch.address;
      val_r  <= in_ch.value;
    end
    if ((state_r == S_DIV1) && div_done) y_r <= div_rem;
    if ((state_r == S_DIV2) && div_done) begin
      x_r <= div_rem;
      z_r <= DW'(div_quot);
    end
    if (state_r == S_SETW) set_r <= fm_rset;
  end

  `ISU_ASSERT(a_role_valid, role_r != 2'd3, "role pointer left its three banks")
  `ISU_ASSERT(a_div_in_seq, div_done |-> (state_r == S_DIV1 || state_r == S_DIV2), "divider finished outside coordinate phase")
  `ISU_ASSERT(a_no_wr_terms, (state_r == S_TERMS) |-> (fm_req.we_fld == 3'b000 && !fm_req.we_set), "field write during neighbor sweep")
  `ISU_ASSERT_NEXT(a_fin_after_mul, state_r == S_MUL, state_r == S_FIN, "gain product not followed by writeback")
endmodule
`default_nettype wire
